FILE: hw/rtl/breakpoint_curve_interpolator_core_assert.svh
// Assertion macros for the breakpoint curve interpolator.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef BREAKPOINT_CURVE_INTERPOLATOR_CORE_ASSERT_SVH
`define BREAKPOINT_CURVE_INTERPOLATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCI_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("breakpoint interpolator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("breakpoint interpolator check failed");

`endif

FILE: hw/rtl/bci_pkg.sv
package bci_pkg;

  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COUNT_W    = 5;
  localparam int NW         = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int ENTRY_W    = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int IN_FIELDS_W = DATA_W + ENTRY_W + DATA_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = DATA_W;

  // Divider: quotient holds the fraction plus the integer bit.
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int DIVIDEND_W = DATA_W + 1;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
  localparam int WIDE_W     = DATA_W + 1;
  localparam int PROD_W     = QUO_W + 1 + WIDE_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_PERIODIC = cfg_idx_t'(0);
  localparam cfg_idx_t REG_COUNT    = cfg_idx_t'(1);

  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic wr;
    logic rot;
  } cell_ctl_t;

  typedef struct packed {
    logic                  start;
    logic [DATA_W-1:0]     rem;
    logic [DIVIDEND_W-1:0] bits;
    logic [STEP_W-1:0]     steps;
    logic [DATA_W-1:0]     divisor;
  } div_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } div_stat_t;

endpackage

FILE: hw/rtl/bci_cell.sv
module bci_cell (
  input  logic                      clk,
  input  bci_pkg::cell_ctl_t        ctl,
  input  logic [bci_pkg::DATA_W-1:0] wr_tm,
  input  logic [bci_pkg::DATA_W-1:0] wr_vel,
  input  logic [bci_pkg::DATA_W-1:0] nb_tm,
  input  logic [bci_pkg::DATA_W-1:0] nb_vel,
  output logic [bci_pkg::DATA_W-1:0] tm_q,
  output logic [bci_pkg::DATA_W-1:0] vel_q
);
  import bci_pkg::*;

  logic [DATA_W-1:0] tm_r, tm_nxt;
  logic [DATA_W-1:0] vel_r, vel_nxt;

  // A write loads the slot; a rotation takes the neighbour's breakpoint.
  always_comb begin
    tm_nxt  = tm_r;
    vel_nxt = vel_r;
    if (ctl.wr) begin
      tm_nxt  = wr_tm;
      vel_nxt = wr_vel;
    end else if (ctl.rot) begin
      tm_nxt  = nb_tm;
      vel_nxt = nb_vel;
    end
  end

  always_ff @(posedge clk) begin
    tm_r  <= tm_nxt;
    vel_r <= vel_nxt;
  end

  assign tm_q  = tm_r;
  assign vel_q = vel_r;

endmodule

FILE: hw/rtl/bci_div.sv
module bci_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bci_pkg::div_cmd_t  cmd,
  output bci_pkg::div_stat_t stat
);
  import bci_pkg::*;

  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_W-1:0]     rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] bits_r, bits_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [DATA_W-1:0]     div_r, div_nxt;
  logic [DATA_W:0]       trial;
  logic [DATA_W:0]       diff;
  logic                  ge;

  // Restoring division, one dividend bit per cycle.
  always_comb begin
    trial    = {rem_r, bits_r[DIVIDEND_W-1]};
    diff     = trial - {1'b0, div_r};
    ge       = (trial >= {1'b0, div_r});
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (cmd.start) begin
      cnt_nxt  = cmd.steps;
      rem_nxt  = cmd.rem;
      bits_nxt = cmd.bits;
      quo_nxt  = '0;
      div_nxt  = cmd.divisor;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      bits_nxt = {bits_r[DIVIDEND_W-2:0], 1'b0};
      quo_nxt  = {quo_r[QUO_W-2:0], ge};
      cnt_nxt  = cnt_r - STEP_W'(1);
      done_nxt = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign stat.rem  = rem_r;
  assign stat.quo  = quo_r;

endmodule

FILE: hw/rtl/breakpoint_curve_interpolator_core.sv
// Piecewise linear velocity curve over up to MAX_POINTS breakpoints (Q16.16).
// Input words carry either a breakpoint write (in_tuser high) or an evaluate
// request (in_tuser low); only an evaluate produces an output word, which
// carries the interpolated velocity and, in out_tuser, the degenerate flag.
// The configuration port sets periodic or clamp mode and the point count; the
// user must write it only while the block is idle, which the block does not enforce.
// The breakpoints sit in a ring of cells that rotates by one slot per cycle
// during the two passes of an evaluate. A write loads its cell directly. An
// evaluate ends after the first pass for a degenerate table or a clamped
// time; an interpolation in clamp mode adds the second pass and a fraction
// division, and periodic mode first runs the wrap through the bit-serial
// divider, one bit per cycle. One word is in work at a time.
// Reset is synchronous and active low; it selects clamp mode with one point
// and empties the output register, while the breakpoint table keeps whatever
// it held. A stalled receiver holds the finished word in the output register;
// the next word is accepted meanwhile and waits only at its own result.
`include "breakpoint_curve_interpolator_core_assert.svh"

module breakpoint_curve_interpolator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, lowest bit first: query_time[31:0], entry_index[35:32],
  // entry_time[67:36], entry_velocity[99:68], zero padding.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bci_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: op (0 evaluate, 1 write one breakpoint).
  input  logic                              in_tuser,
  // out_tdata: velocity[31:0].
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bci_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: degenerate.
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic [bci_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bci_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bci_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_PASS_A    = 10'b0000000010,
    ST_PREP      = 10'b0000000100,
    ST_MOD       = 10'b0000001000,
    ST_PASS_B    = 10'b0000010000,
    ST_FRAC_PREP = 10'b0000100000,
    ST_FRAC_WAIT = 10'b0001000000,
    ST_MUL       = 10'b0010000000,
    ST_SUM       = 10'b0100000000,
    ST_DONE      = 10'b1000000000
  } state_t;

  // Input fields.
  logic [DATA_W-1:0]  in_query;
  logic [ENTRY_W-1:0] in_index;
  logic [DATA_W-1:0]  in_etime;
  logic [DATA_W-1:0]  in_evel;

  assign in_query = in_tdata[DATA_W-1:0];
  assign in_index = in_tdata[DATA_W+ENTRY_W-1:DATA_W];
  assign in_etime = in_tdata[2*DATA_W+ENTRY_W-1:DATA_W+ENTRY_W];
  assign in_evel  = in_tdata[3*DATA_W+ENTRY_W-1:2*DATA_W+ENTRY_W];

  // Control registers.
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic               periodic_r, periodic_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers.
  logic [DATA_W-1:0]  q_r, q_nxt;
  logic [DATA_W-1:0]  t0_r, t0_nxt, v0_r, v0_nxt;
  logic [DATA_W-1:0]  tl_r, tl_nxt, vl_r, vl_nxt;
  logic [WIDE_W-1:0]  span_r, span_nxt;
  logic               neg_r, neg_nxt;
  logic [DATA_W-1:0]  x_r, x_nxt;
  logic [DATA_W-1:0]  ti_r, ti_nxt, vi_r, vi_nxt;
  logic [DATA_W-1:0]  ti1_r, ti1_nxt, vi1_r, vi1_nxt;
  logic [QUO_W-1:0]   a_r, a_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0]  res_r, res_nxt;
  logic               degen_r, degen_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  // Ring of breakpoint cells.
  cell_ctl_t          cell_ctl [MAX_POINTS];
  logic [DATA_W-1:0]  cell_tm  [MAX_POINTS];
  logic [DATA_W-1:0]  cell_vel [MAX_POINTS];

  div_cmd_t           div_cmd;
  div_stat_t          div_stat;

  // Combinational helpers.
  logic               in_acc;
  logic [NW-1:0]      count_ext;
  logic [NW-1:0]      n_eff;
  logic [IDX_W-1:0]   last_idx;
  logic signed [WIDE_W-1:0] span_w, d_w, dx_w, dt_w, dv_w;
  logic [WIDE_W-1:0]  mag_w;
  logic [DATA_W-1:0]  wrap_val;
  logic signed [PROD_W-1:0] shifted;
  logic               rotating;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign rotating  = (state_r == ST_PASS_A) || (state_r == ST_PASS_B);

  // Point count in use: zero acts as one, large values saturate.
  always_comb begin
    count_ext = NW'(count_r);
    if (count_ext == '0) begin
      n_eff = NW'(1);
    end else if (count_ext > NW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = count_ext;
    end
    last_idx = IDX_W'(n_eff - NW'(1));
  end

  for (genvar c = 0; c < MAX_POINTS; c++) begin : g_cell
    assign cell_ctl[c].wr  = in_acc && (in_tuser == OP_WRITE) &&
                             ((ENTRY_W + IDX_W + 1)'(in_index) ==
                              (ENTRY_W + IDX_W + 1)'(c));
    assign cell_ctl[c].rot = rotating;

    bci_cell u_cell (
      .clk    (clk),
      .ctl    (cell_ctl[c]),
      .wr_tm  (in_etime),
      .wr_vel (in_evel),
      .nb_tm  (cell_tm[(c + 1) % MAX_POINTS]),
      .nb_vel (cell_vel[(c + 1) % MAX_POINTS]),
      .tm_q   (cell_tm[c]),
      .vel_q  (cell_vel[c])
    );
  end

  bci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .stat  (div_stat)
  );

  // Sequencer. Cell 0 is the head of the ring: during a pass it shows
  // breakpoint k, and cell 1 shows breakpoint k+1.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    periodic_nxt  = periodic_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    q_nxt         = q_r;
    t0_nxt        = t0_r;
    v0_nxt        = v0_r;
    tl_nxt        = tl_r;
    vl_nxt        = vl_r;
    span_nxt      = span_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    ti_nxt        = ti_r;
    vi_nxt        = vi_r;
    ti1_nxt       = ti1_r;
    vi1_nxt       = vi1_r;
    a_nxt         = a_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    degen_nxt     = degen_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    div_cmd         = '0;
    div_cmd.divisor = span_r[DATA_W-1:0];

    span_w  = $signed({tl_r[DATA_W-1], tl_r}) - $signed({t0_r[DATA_W-1], t0_r});
    d_w     = $signed({q_r[DATA_W-1], q_r}) - $signed({t0_r[DATA_W-1], t0_r});
    mag_w   = d_w[WIDE_W-1] ? WIDE_W'(-d_w) : WIDE_W'(d_w);
    dx_w    = $signed({x_r[DATA_W-1], x_r}) - $signed({ti_r[DATA_W-1], ti_r});
    dt_w    = $signed({ti1_r[DATA_W-1], ti1_r}) - $signed({ti_r[DATA_W-1], ti_r});
    dv_w    = $signed({vi1_r[DATA_W-1], vi1_r}) - $signed({vi_r[DATA_W-1], vi_r});
    shifted = prod_r >>> FRAC_BITS;
    wrap_val = (neg_r && (div_stat.rem != '0)) ?
               (span_r[DATA_W-1:0] - div_stat.rem) : div_stat.rem;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIODIC: periodic_nxt = cfg_wdata[0];
        REG_COUNT:    count_nxt    = COUNT_W'(cfg_wdata);
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_EVAL)) begin
          q_nxt     = in_query;
          k_nxt     = '0;
          state_nxt = ST_PASS_A;
        end
      end

      ST_PASS_A: begin
        if (k_r == '0) begin
          t0_nxt = cell_tm[0];
          v0_nxt = cell_vel[0];
        end
        if (k_r == last_idx) begin
          tl_nxt = cell_tm[0];
          vl_nxt = cell_vel[0];
        end
        k_nxt = k_r + IDX_W'(1);
        if (k_r == IDX_W'(MAX_POINTS - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_PREP;
        end
      end

      ST_PREP: begin
        span_nxt  = span_w;
        degen_nxt = 1'b0;
        if ((n_eff == NW'(1)) || span_w[WIDE_W-1] || (span_w == '0)) begin
          // Single point, or an empty or negative span.
          res_nxt   = v0_r;
          degen_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (periodic_r) begin
          neg_nxt         = d_w[WIDE_W-1];
          div_cmd.start   = 1'b1;
          div_cmd.rem     = '0;
          div_cmd.bits    = DIVIDEND_W'(mag_w);
          div_cmd.steps   = STEP_W'(DIVIDEND_W);
          div_cmd.divisor = span_w[DATA_W-1:0];
          state_nxt       = ST_MOD;
        end else if ($signed(q_r) < $signed(t0_r)) begin
          res_nxt   = v0_r;
          state_nxt = ST_DONE;
        end else if ($signed(q_r) > $signed(tl_r)) begin
          res_nxt   = vl_r;
          state_nxt = ST_DONE;
        end else begin
          x_nxt     = q_r;
          state_nxt = ST_PASS_B;
        end
      end

      ST_MOD: begin
        if (div_stat.done) begin
          // Floored remainder, moved back to start at the first breakpoint.
          x_nxt     = t0_r + wrap_val;
          state_nxt = ST_PASS_B;
        end
      end

      ST_PASS_B: begin
        // Keep the last segment whose left end is at or below x.
        if ((k_r == '0) ||
            (((NW'(k_r) + NW'(1)) < n_eff) && ($signed(cell_tm[0]) <= $signed(x_r)))) begin
          ti_nxt  = cell_tm[0];
          vi_nxt  = cell_vel[0];
          ti1_nxt = cell_tm[1 % MAX_POINTS];
          vi1_nxt = cell_vel[1 % MAX_POINTS];
        end
        k_nxt = k_r + IDX_W'(1);
        if (k_r == IDX_W'(MAX_POINTS - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_FRAC_PREP;
        end
      end

      ST_FRAC_PREP: begin
        if (dt_w[WIDE_W-1] || (dt_w == '0) || dx_w[WIDE_W-1]) begin
          res_nxt   = vi_r;
          state_nxt = ST_DONE;
        end else if (dx_w == dt_w) begin
          a_nxt     = QUO_W'(1) << FRAC_BITS;
          state_nxt = ST_MUL;
        end else begin
          // x lies inside the segment, so dx < dt and only fraction bits remain.
          div_cmd.start   = 1'b1;
          div_cmd.rem     = dx_w[DATA_W-1:0];
          div_cmd.bits    = '0;
          div_cmd.steps   = STEP_W'(FRAC_BITS);
          div_cmd.divisor = dt_w[DATA_W-1:0];
          state_nxt       = ST_FRAC_WAIT;
        end
      end

      ST_FRAC_WAIT: begin
        if (div_stat.done) begin
          a_nxt     = div_stat.quo;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        // Both operands are widened to the product width before multiplying.
        prod_nxt  = $signed({{(PROD_W-QUO_W){1'b0}}, a_r}) *
                    $signed({{(PROD_W-WIDE_W){dv_w[WIDE_W-1]}}, dv_w});
        state_nxt = ST_SUM;
      end

      ST_SUM: begin
        res_nxt   = vi_r + shifted[DATA_W-1:0];
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_user_nxt  = degen_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      periodic_r  <= 1'b0;
      count_r     <= COUNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      periodic_r  <= periodic_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    t0_r       <= t0_nxt;
    v0_r       <= v0_nxt;
    tl_r       <= tl_nxt;
    vl_r       <= vl_nxt;
    span_r     <= span_nxt;
    neg_r      <= neg_nxt;
    x_r        <= x_nxt;
    ti_r       <= ti_nxt;
    vi_r       <= vi_nxt;
    ti1_r      <= ti1_nxt;
    vi1_r      <= vi1_nxt;
    a_r        <= a_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    degen_r    <= degen_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Writes land in the slot they name only if the ring is at rest.
  `BCI_ASSERT_NOW(a_ring_aligned, state_r == ST_IDLE, k_r == '0)
  `BCI_ASSERT_NEXT(a_eval_starts, in_tvalid && in_tready && (in_tuser == OP_EVAL),
                   (state_r == ST_PASS_A) && (k_r == '0))
  `BCI_ASSERT_NOW(a_div_done_awaited, div_stat.done,
                  (state_r == ST_MOD) || (state_r == ST_FRAC_WAIT))
  `BCI_ASSERT_NOW(a_div_idle_when_ready, in_tready, !div_stat.busy)

endmodule
